### rtl/core/time_ordered_job_queue_macros.svh
// assertion macros used by the job queue top level
`ifndef TIME_ORDERED_JOB_QUEUE_MACROS_SVH
`define TIME_ORDERED_JOB_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define TOJQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define TOJQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### rtl/core/tojq_pkg.sv
// types and constants of the time-ordered job queue
`timescale 1ns / 1ps

package tojq_pkg;

  localparam int ID_W   = 16;
  localparam int PID_W  = 22;
  localparam int KEY_W  = 38;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int IN_W   = 80;
  localparam int OUT_USER_W = 3;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PID_W-1:0] pid;
    logic [ID_W-1:0]  id;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    logic   rem;
    entry_t item;
  } ctrl_t;

endpackage

### rtl/core/tojq_cell.sv
// one slot of the sorted job chain
`timescale 1ns / 1ps

module tojq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  tojq_pkg::ctrl_t     ctrl,
  input  logic [CNT_W-1:0]    count,
  input  tojq_pkg::entry_t    prev_entry,
  input  logic                prev_ge,
  input  tojq_pkg::entry_t    next_entry,
  input  logic                next_hit,
  input  tojq_pkg::entry_t    next_pick,
  output tojq_pkg::entry_t    entry,
  output logic                ge,
  output logic                hit,
  output tojq_pkg::entry_t    pick
);

  logic valid;
  logic match;

  assign valid = count > CNT_W'(INDEX);
  // new job lands before any job with an equal or later key
  assign ge    = !valid || (ctrl.item.key <= entry.key);
  assign match = valid && (ctrl.item.id == entry.id);
  assign hit   = match || next_hit;
  // highest matching slot wins
  assign pick  = (match && !next_hit) ? entry : next_pick;

  always_ff @(posedge clk) begin
    if (ctrl.ins && ge) begin
      entry <= prev_ge ? prev_entry : ctrl.item;
    end else if (ctrl.pop) begin
      entry <= next_entry;
    end else if (ctrl.rem && !next_hit) begin
      entry <= next_entry;
    end
  end

endmodule

### rtl/core/time_ordered_job_queue.sv
// top level of the time-ordered job queue
//
//  channel  | dir | beat carries
//  ---------+-----+--------------------------------------------------------
//  s_*      | in  | one command: insert, pop earliest, or remove by id
//  m_*      | out | one result per command: status, removed job, count
//
// each command is captured in the idle state, then executed in the exec state, in
// which the whole cell chain updates together and the result register loads
// the execute cycle waits while the result register holds an untaken beat
// the critical path is the id-match ripple through all queue_depth cells
// rst clears the count, the control state and the result valid; the cells
// hold no reset and only slots below the count are ever read
`timescale 1ns / 1ps
`include "time_ordered_job_queue_macros.svh"

module time_ordered_job_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // job_id [15:0], process_id [37:16], time_key [75:38], zero pad
  input  logic [tojq_pkg::IN_W-1:0] s_tdata,
  // kind [1:0]
  input  logic [tojq_pkg::KIND_W-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // out_job_id [15:0], out_process_id [37:16], out_time_key [75:38],
  // entry_count above that, zero pad to whole bytes
  output logic [((tojq_pkg::ID_W + tojq_pkg::PID_W + tojq_pkg::KEY_W
                  + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  // status [1:0], entry_valid [2]
  output logic [tojq_pkg::OUT_USER_W-1:0] m_tuser
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int FLD_W  = tojq_pkg::ID_W + tojq_pkg::PID_W + tojq_pkg::KEY_W;
  localparam int DATA_W = ((FLD_W + CNT_W + 7) / 8) * 8;
  localparam int PID_LO = tojq_pkg::ID_W;
  localparam int KEY_LO = tojq_pkg::ID_W + tojq_pkg::PID_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [tojq_pkg::KIND_W-1:0]   op_kind;
  tojq_pkg::entry_t              op_item;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic                          exec_fire;
  logic                          found;
  logic                          is_full;
  logic                          is_empty;
  tojq_pkg::ctrl_t               ctrl;
  logic [tojq_pkg::STAT_W-1:0]   res_status;
  logic                          res_valid;
  tojq_pkg::entry_t              res_entry;
  logic [DATA_W-1:0]             tdata_next;

  // chain wiring: prev_* runs from slot 0 upward, next_* from the far end down
  tojq_pkg::entry_t cell_entry [QUEUE_DEPTH];
  tojq_pkg::entry_t cell_pick  [QUEUE_DEPTH];
  tojq_pkg::entry_t prev_entry [QUEUE_DEPTH];
  tojq_pkg::entry_t next_entry [QUEUE_DEPTH];
  tojq_pkg::entry_t next_pick  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH-1:0] cell_hit;
  logic [QUEUE_DEPTH-1:0] prev_ge;
  logic [QUEUE_DEPTH-1:0] next_hit;

  assign s_tready  = (state == ST_IDLE);
  // execute only when the result register is free or being drained
  assign exec_fire = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign is_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  // slot 0 sees the ripple of every match at or above it
  assign found    = cell_hit[0];

  always_comb begin
    ctrl      = '0;
    ctrl.item = op_item;
    ctrl.ins  = exec_fire && (op_kind == tojq_pkg::KIND_INSERT) && !is_full;
    ctrl.pop  = exec_fire && (op_kind == tojq_pkg::KIND_POP) && !is_empty;
    ctrl.rem  = exec_fire && (op_kind == tojq_pkg::KIND_REMOVE) && found;
  end

  // slot 0 is the earliest job; slots climb towards later keys
  for (genvar c = 0; c < QUEUE_DEPTH; c++) begin : g_cell
    if (c == 0) begin : g_first
      assign prev_entry[c] = '0;
      assign prev_ge[c]    = 1'b0;
    end else begin : g_inner
      assign prev_entry[c] = cell_entry[c-1];
      assign prev_ge[c]    = cell_ge[c-1];
    end
    if (c == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry[c] = '0;
      assign next_hit[c]   = 1'b0;
      assign next_pick[c]  = '0;
    end else begin : g_below
      assign next_entry[c] = cell_entry[c+1];
      assign next_hit[c]   = cell_hit[c+1];
      assign next_pick[c]  = cell_pick[c+1];
    end

    tojq_cell #(
      .INDEX (c),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .prev_entry (prev_entry[c]),
      .prev_ge    (prev_ge[c]),
      .next_entry (next_entry[c]),
      .next_hit   (next_hit[c]),
      .next_pick  (next_pick[c]),
      .entry      (cell_entry[c]),
      .ge         (cell_ge[c]),
      .hit        (cell_hit[c]),
      .pick       (cell_pick[c])
    );
  end

  // result of the command in flight
  always_comb begin
    res_status = tojq_pkg::STAT_OK;
    res_valid  = 1'b0;
    res_entry  = '0;
    count_next = count;
    case (op_kind)
      tojq_pkg::KIND_INSERT: begin
        if (is_full) begin
          res_status = tojq_pkg::STAT_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      tojq_pkg::KIND_POP: begin
        if (is_empty) begin
          res_status = tojq_pkg::STAT_EMPTY;
        end else begin
          res_valid  = 1'b1;
          res_entry  = cell_entry[0];
          count_next = count - CNT_W'(1);
        end
      end
      tojq_pkg::KIND_REMOVE: begin
        if (!found) begin
          res_status = tojq_pkg::STAT_NOTFOUND;
        end else begin
          res_valid  = 1'b1;
          res_entry  = cell_pick[0];
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        // unused kind: report the count, change nothing
        res_status = tojq_pkg::STAT_OK;
      end
    endcase
  end

  always_comb begin
    tdata_next = '0;
    tdata_next[PID_LO-1:0]        = res_entry.id;
    tdata_next[KEY_LO-1:PID_LO]   = res_entry.pid;
    tdata_next[FLD_W-1:KEY_LO]    = res_entry.key;
    tdata_next[FLD_W+CNT_W-1:FLD_W] = count_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // captured command and result beat, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_kind      <= s_tuser;
      op_item.id   <= s_tdata[PID_LO-1:0];
      op_item.pid  <= s_tdata[KEY_LO-1:PID_LO];
      op_item.key  <= s_tdata[FLD_W-1:KEY_LO];
    end
    if (exec_fire) begin
      m_tdata <= tdata_next;
      m_tuser <= {res_valid, res_status};
    end
  end

  `TOJQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(QUEUE_DEPTH), "count beyond depth")

  `TOJQ_ASSERT_NOW(a_head_sorted, count >= CNT_W'(2), cell_entry[0].key <= cell_entry[1].key, "head out of order")

  `TOJQ_ASSERT_NEXT(a_removal_shrinks, exec_fire && res_valid, count == $past(count) - CNT_W'(1), "removal did not shrink count")

  `TOJQ_ASSERT_NOW(a_full_report, m_tvalid && m_tuser[1:0] == tojq_pkg::STAT_FULL, m_tdata[FLD_W+CNT_W-1:FLD_W] == CNT_W'(QUEUE_DEPTH), "full status with spare room")

endmodule
